// ===== rtl/rme_pkg.sv =====
// Shared types and constants for the row median engine.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package rme_pkg;

	// Width of the used-sample count on the result beat.
	localparam int USED_W = 7;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_PLACE,
		S_MED0,
		S_MED1,
		S_MED2,
		S_EMIT
	} rme_state_t;

endpackage

// ===== rtl/rme_in_if.sv =====
// Sample channel: valid/ready handshake carrying one sample and the row-end flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface rme_in_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;
	logic                   row_end;

	modport source (output valid, output sample, output row_end, input ready);
	modport sink (input valid, input sample, input row_end, output ready);
endinterface

// ===== rtl/rme_out_if.sv =====
// Result channel: valid/ready handshake carrying the doubled median and row status.
// Depends on rme_pkg for the count width.
`timescale 1ns / 1ps

interface rme_out_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                        valid;
	logic                        ready;
	logic [SAMPLE_BITS:0]        median_doubled;
	logic [rme_pkg::USED_W-1:0]  samples_used;
	logic                        overflowed;

	modport source (output valid, output median_doubled, output samples_used,
		output overflowed, input ready);
	modport sink (input valid, input median_doubled, input samples_used,
		input overflowed, output ready);
endinterface

// ===== rtl/rme_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== rtl/row_median_engine.sv =====
// Row median engine: sorts the samples of a row into a RAM and reports the median.
// Depends on rme_pkg, rme_in_if, rme_out_if and rme_ram.
`timescale 1ns / 1ps

// Usage
//   samples (sink): one signed sample per beat; row_end marks the row's last beat.
//   result (source): one beat per row, with twice the median, the number of
//   samples it was taken over and a flag for samples dropped on a full store.
// Each sample is placed by insertion: a read/compare/write walk down the sorted
// RAM, where the single comparator moves every entry greater than the sample up
// one place. A row's first sample is written without a walk, and a dropped sample
// is taken in the idle state with no walk at all. The RAM's one read port and the
// compare loop set the pace of placement. At row end the median is formed with one
// shared adder, from the middle entry (odd count) or the two middle entries (even
// count), and the emit state loads it into the output register once that is free.
// The samples port is ready only while no item is in progress. A finished result
// waits in the output register while the next row already streams in; if the
// receiver still stalls when the next row ends, the engine holds until it drains.
// Reset clears the fill count, the drop flag, the state and the output valid;
// RAM contents are left as they are and are only read where written.
module row_median_engine #(
	parameter int MAX_ROW_LEN = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rme_in_if.sink    samples,
	rme_out_if.source result
);
	import rme_pkg::*;

	localparam int ADDR_W = $clog2(MAX_ROW_LEN);
	localparam int CNT_W  = $clog2(MAX_ROW_LEN + 1);

	rme_state_t state_q, state_d;

	logic [CNT_W-1:0]       fill_q;
	logic                   drop_q;
	logic [ADDR_W-1:0]      pos_q;
	logic [SAMPLE_BITS-1:0] smp_q;
	logic                   row_end_q;
	logic [SAMPLE_BITS-1:0] b_q;
	logic [SAMPLE_BITS:0]   sum_q;

	logic                   res_vld_q;
	logic [SAMPLE_BITS:0]   res_med_q;
	logic [USED_W-1:0]      res_used_q;
	logic                   res_ovf_q;

	logic                   ram_we;
	logic [ADDR_W-1:0]      ram_waddr;
	logic [SAMPLE_BITS-1:0] ram_wdata;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	logic                   accept;
	logic                   full;
	logic                   gt;
	logic                   odd;
	logic [ADDR_W-1:0]      half;
	logic [SAMPLE_BITS-1:0] add_a, add_b;
	logic [SAMPLE_BITS:0]   add_sum;
	logic                   emit_go;

	rme_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_ROW_LEN)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept  = samples.valid && samples.ready;
	assign full    = (fill_q >= CNT_W'(MAX_ROW_LEN));
	assign gt      = ($signed(ram_rdata) > $signed(smp_q));
	assign odd     = fill_q[0];
	assign half    = ADDR_W'(fill_q >> 1);
	assign emit_go = !res_vld_q || result.ready;

	// Shared adder: doubles the middle entry, or sums the two middle entries.
	always_comb begin
		add_a = ram_rdata;
		add_b = (state_q == S_MED2) ? b_q : ram_rdata;
	end
	assign add_sum = {add_a[SAMPLE_BITS-1], add_a} + {add_b[SAMPLE_BITS-1], add_b};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (samples.valid) begin
					if (full) begin
						state_d = samples.row_end ? S_MED0 : S_IDLE;
					end else if (fill_q == '0) begin
						state_d = S_PLACE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: state_d = S_CMP;
			S_CMP: begin
				if (gt && pos_q != ADDR_W'(1)) begin
					state_d = S_READ;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: state_d = row_end_q ? S_MED0 : S_IDLE;
			S_MED0:  state_d = S_MED1;
			S_MED1:  state_d = odd ? S_EMIT : S_MED2;
			S_MED2:  state_d = S_EMIT;
			S_EMIT:  state_d = emit_go ? S_IDLE : S_EMIT;
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs to the RAM and the sample port
	always_comb begin
		samples.ready = 1'b0;
		ram_we        = 1'b0;
		ram_waddr     = pos_q;
		ram_wdata     = smp_q;
		ram_raddr     = '0;
		unique case (state_q)
			S_IDLE:  samples.ready = 1'b1;
			S_READ:  ram_raddr = pos_q - ADDR_W'(1);
			S_CMP: begin
				// shift the larger entry up one place
				ram_we    = gt;
				ram_wdata = ram_rdata;
			end
			S_PLACE: ram_we = 1'b1;
			S_MED0:  ram_raddr = half;
			S_MED1:  ram_raddr = half - ADDR_W'(1);
			S_MED2, S_EMIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			drop_q    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && full) begin
				drop_q <= 1'b1;
			end
			if (state_q == S_PLACE) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (state_q == S_EMIT && emit_go) begin
				res_vld_q <= 1'b1;
				fill_q    <= '0;
				drop_q    <= 1'b0;
			end else if (result.valid && result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q     <= samples.sample;
			row_end_q <= samples.row_end;
			pos_q     <= ADDR_W'(fill_q);
		end
		if (state_q == S_CMP && gt) begin
			pos_q <= pos_q - ADDR_W'(1);
		end
		if (state_q == S_MED1) begin
			b_q <= ram_rdata;
			if (odd) begin
				sum_q <= add_sum;
			end
		end
		if (state_q == S_MED2) begin
			sum_q <= add_sum;
		end
		if (state_q == S_EMIT && emit_go) begin
			res_med_q  <= sum_q;
			res_used_q <= USED_W'(fill_q);
			res_ovf_q  <= drop_q;
		end
	end

	assign result.valid          = res_vld_q;
	assign result.median_doubled = res_med_q;
	assign result.samples_used   = res_used_q;
	assign result.overflowed     = res_ovf_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_ROW_LEN))
		else $error("fill count beyond store depth");

	a_drop_set: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full) |=> drop_q)
		else $error("dropped sample not flagged");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CNT_W'(ram_waddr) <= fill_q) && !full)
		else $error("store write outside filled range");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && emit_go) |=> (fill_q == '0) && res_vld_q)
		else $error("row state not cleared on result load");
endmodule
